// File: hdl/siw_pkg.sv
package siw_pkg;

  // Number of axes the walker supports
  localparam int MAX_RANK = 4;

  // Field widths
  localparam int RANK_CFG_W = 3;
  localparam int LEN_W      = 8;
  localparam int CNT_W      = LEN_W;
  localparam int WORD_W     = 32;
  localparam int ASTR_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int RANK_W     = $clog2(MAX_RANK + 1);

  // Stream payload widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 2 * WORD_W + LEN_W + ASTR_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARRAY_RANK    = 3'd0,
    CFG_AXIS_LEN_0    = 3'd1,
    CFG_AXIS_LEN_1    = 3'd2,
    CFG_AXIS_LEN_2    = 3'd3,
    CFG_AXIS_LEN_3    = 3'd4,
    CFG_COLLAPSE_ON   = 3'd5,
    CFG_COLLAPSE_AXIS = 3'd6
  } cfg_idx_e;

  // Partial result handed from one axis cell to the next outer one
  typedef struct packed {
    logic [WORD_W-1:0] stride;    // stride of the axis that receives this
    logic [WORD_W-1:0] offset;    // offset summed over inner axes
    logic [WORD_W-1:0] wsize;     // walk size over inner axes
    logic [ASTR_W-1:0] astr;      // stride of the collapsed axis
    logic              last;      // all inner walked axes at final value
    logic              carry;     // odometer carry into this axis
    logic              restart;   // counters restart with this item
  } siw_bus_t;

  // Static per-axis control, derived from the configuration registers
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             in_rank;
    logic             walked;
    logic             collapsed;
  } siw_cell_cfg_t;

endpackage

// File: hdl/siw_cell.sv
module siw_cell import siw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  siw_cell_cfg_t cfg_i,
  input  logic          in_valid_i,
  input  siw_bus_t      in_bus_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output siw_bus_t      out_bus_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W:0]    cnt_nxt;
  logic [WORD_W-1:0] stride;
  logic              valid_q;
  siw_bus_t          bus_q, bus_d;

  // One axis: offset term, size term, stride product and odometer digit
  always_comb begin
    cnt_eff = in_bus_i.restart ? '0 : cnt_q;
    cnt_nxt = {1'b0, cnt_eff} + {{CNT_W{1'b0}}, 1'b1};
    stride  = cfg_i.in_rank ? in_bus_i.stride : '0;
    bus_d   = in_bus_i;
    cnt_d   = cnt_eff;
    if (cfg_i.in_rank) begin
      bus_d.stride = WORD_W'(in_bus_i.stride * {{(WORD_W-LEN_W){1'b0}}, cfg_i.len});
    end
    if (cfg_i.collapsed) begin
      bus_d.astr = stride[ASTR_W-1:0];
    end
    if (cfg_i.walked) begin
      bus_d.offset = in_bus_i.offset +
                     WORD_W'({{(WORD_W-CNT_W){1'b0}}, cnt_eff} * stride);
      bus_d.wsize  = WORD_W'(in_bus_i.wsize * {{(WORD_W-LEN_W){1'b0}}, cfg_i.len});
      if (cnt_nxt < {1'b0, cfg_i.len}) begin
        bus_d.last = 1'b0;
      end
      if (in_bus_i.carry) begin
        if (cnt_nxt >= {1'b0, cfg_i.len}) begin
          cnt_d       = '0;
          bus_d.carry = 1'b1;
        end else begin
          cnt_d       = cnt_nxt[CNT_W-1:0];
          bus_d.carry = 1'b0;
        end
      end
    end
  end

  // Position counter and hand-off register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_valid_i) begin
        cnt_q   <= cnt_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      bus_q <= bus_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_bus_o   = bus_q;

endmodule

// File: hdl/strided_index_walker.sv
// Row-major index walker over up to MAX_RANK axes.
// Configuration: plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user
// must write it only while no item is in flight; the block does not enforce it.
// Index 0 rank, 1..4 axis lengths, 5 collapse enable, 6 collapse axis, 7 ignored.
// Input stream: one item per request, s_axis_tdata[0] = restart.
// Output stream: one result per request with the offset of the current
// position; m_axis_tlast flags the final position of the walk.
// Each axis is a cell in a chain from the innermost to the outermost axis;
// an item moves one cell per cycle, carrying the running stride, offset,
// walk size, last flag and odometer carry. Each cell holds its counter.
// A new item is accepted only once the previous one moves from the outermost
// cell into the output register; that move overlaps the entry of the next item.
// Reset: rank 0, all lengths 1, collapse off, all counters zero.
// A stalled receiver holds the result in the output register; one more item
// is accepted and walks the chain, then waits in the outermost cell until
// the output register frees. Further items wait at s_axis_tready.
module strided_index_walker import siw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] offset, [63:32] walk_size,
                                                // [71:64] axis_length, [95:72] axis_stride
  output logic                  m_axis_tlast,   // last
  output logic                  m_axis_tuser    // [0] axis_error
);

  logic [RANK_CFG_W-1:0] rank_q;
  logic [LEN_W-1:0]      axis_len_q [MAX_RANK];
  logic                  coll_on_q;
  logic [1:0]            coll_axis_q;

  logic [RANK_W-1:0]     eff_rank;
  logic                  coll;
  logic                  err;
  logic [LEN_W-1:0]      alen;
  siw_cell_cfg_t         cell_cfg [MAX_RANK];

  siw_bus_t              chain_bus   [MAX_RANK+1];
  logic [MAX_RANK:0]     chain_valid;
  logic [MAX_RANK-1:0]   chain_ready;

  logic                  busy_q;
  logic                  s_accept;
  logic                  take;
  logic                  out_valid_q;
  logic [M_TDATA_W-1:0]  out_data_q;
  logic                  out_last_q;
  logic                  out_err_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= '0;
      coll_on_q   <= 1'b0;
      coll_axis_q <= '0;
      for (int i = 0; i < MAX_RANK; i++) begin
        axis_len_q[i] <= LEN_W'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ARRAY_RANK:    rank_q      <= cfg_wdata_i[RANK_CFG_W-1:0];
        CFG_COLLAPSE_ON:   coll_on_q   <= cfg_wdata_i[0];
        CFG_COLLAPSE_AXIS: coll_axis_q <= cfg_wdata_i[1:0];
        CFG_AXIS_LEN_0, CFG_AXIS_LEN_1, CFG_AXIS_LEN_2, CFG_AXIS_LEN_3: begin
          // lengths for axes beyond MAX_RANK are dropped
          for (int i = 0; i < MAX_RANK; i++) begin
            if (int'(cfg_idx_i) - int'(CFG_AXIS_LEN_0) == i) begin
              axis_len_q[i] <= cfg_wdata_i[LEN_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Effective rank, collapse decode and per-cell control
  always_comb begin
    if (int'(rank_q) > MAX_RANK) begin
      eff_rank = RANK_W'(MAX_RANK);
    end else begin
      eff_rank = RANK_W'(rank_q);
    end
    coll = coll_on_q && (int'(coll_axis_q) < int'(eff_rank));
    err  = coll_on_q && !coll;
    alen = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      cell_cfg[i].len       = axis_len_q[i];
      cell_cfg[i].in_rank   = i < int'(eff_rank);
      cell_cfg[i].collapsed = coll && (int'(coll_axis_q) == i);
      cell_cfg[i].walked    = cell_cfg[i].in_rank && !cell_cfg[i].collapsed;
      if (cell_cfg[i].collapsed) begin
        alen = axis_len_q[i];
      end
    end
  end

  // Chain entry: seed values for the innermost axis
  assign take          = chain_valid[0] && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || take;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign chain_valid[MAX_RANK]       = s_accept;
  assign chain_bus[MAX_RANK].stride  = WORD_W'(1);
  assign chain_bus[MAX_RANK].offset  = '0;
  assign chain_bus[MAX_RANK].wsize   = WORD_W'(1);
  assign chain_bus[MAX_RANK].astr    = '0;
  assign chain_bus[MAX_RANK].last    = 1'b1;
  assign chain_bus[MAX_RANK].carry   = 1'b1;
  assign chain_bus[MAX_RANK].restart = s_axis_tdata[0];

  // Axis cells, innermost at the highest index
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
    if (g == 0) begin : g_outer
      assign chain_ready[g] = take;
    end else begin : g_inner
      assign chain_ready[g] = 1'b1;
    end
    siw_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cell_cfg[g]),
      .in_valid_i  (chain_valid[g+1]),
      .in_bus_i    (chain_bus[g+1]),
      .out_ready_i (chain_ready[g]),
      .out_valid_o (chain_valid[g]),
      .out_bus_o   (chain_bus[g])
    );
  end

  // Busy flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= {chain_bus[0].astr, alen, chain_bus[0].wsize, chain_bus[0].offset};
      out_last_q <= chain_bus[0].last;
      out_err_q  <= err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

`ifndef SYNTHESIS
  // at most one item is inside the cell chain
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid[MAX_RANK-1:0]))
    else $error("more than one item in the axis chain");

  // an idle block has an empty chain
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> chain_valid[MAX_RANK-1:0] == '0)
    else $error("chain holds an item while idle");

  // an accepted item enters the innermost cell
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> chain_valid[MAX_RANK-1])
    else $error("accepted item did not enter the chain");

  // a finished item waits in the outer cell until the output frees
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[0] && !take |=> chain_valid[0] && busy_q)
    else $error("finished item lost before output");
`endif

endmodule
